### hw/rtl/fmpd_pkg.sv
package fmpd_pkg;

  // Defaults for the top-level parameters.
  localparam int CordicStagesDef = 16;
  localparam int SampleBitsDef   = 16;
  localparam int MaxStages       = 24;

  // Phase word and gain format.
  localparam int PhaseW       = 16;
  localparam int GainW        = 16;
  localparam int GainFracBits = 12;
  localparam int DemodW       = 20;
  localparam logic [PhaseW-1:0] PhasePi = 16'h8000;
  localparam logic signed [GainW-1:0] GainReset = 16'sd4096;

  // Register file: one register at byte address 0.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic RegDemodGain = 1'b0;

  // Input sample transfer.
  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               block_end;
  } in_item_t;

  // Output result transfer.
  typedef struct packed {
    logic signed [DemodW-1:0] demod_value;
    logic                     block_end_out;
  } out_item_t;

  // Control that travels with the data along the cell chain.
  typedef struct packed {
    logic valid;
    logic zero;
    logic block_end;
  } cell_ctl_t;

  // Rotation angle of iteration k, in units of pi/32768.
  function automatic logic [PhaseW-1:0] atan_const(input int k);
    logic [PhaseW-1:0] a;
    case (k)
      0:       a = 16'd8192;
      1:       a = 16'd4836;
      2:       a = 16'd2555;
      3:       a = 16'd1297;
      4:       a = 16'd651;
      5:       a = 16'd326;
      6:       a = 16'd163;
      7:       a = 16'd81;
      8:       a = 16'd41;
      9:       a = 16'd20;
      10:      a = 16'd10;
      11:      a = 16'd5;
      12:      a = 16'd3;
      13:      a = 16'd1;
      14:      a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/fmpd_cell.sv
module fmpd_cell #(
  parameter int XW    = 19,
  parameter int STAGE = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  fmpd_pkg::cell_ctl_t      ctl_i,
  input  logic signed [XW-1:0]     x_i,
  input  logic signed [XW-1:0]     y_i,
  input  logic [fmpd_pkg::PhaseW-1:0] z_i,
  output fmpd_pkg::cell_ctl_t      ctl_o,
  output logic signed [XW-1:0]     x_o,
  output logic signed [XW-1:0]     y_o,
  output logic [fmpd_pkg::PhaseW-1:0] z_o
);
  import fmpd_pkg::*;

  logic signed [XW-1:0] xs, ys;
  logic signed [XW-1:0] x_d, y_d, x_q, y_q;
  logic [PhaseW-1:0]    z_d, z_q;
  cell_ctl_t            ctl_q;

  // One vectoring rotation: drive y toward zero and track the angle.
  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_const(STAGE);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_const(STAGE);
    end
  end

  // Control register; cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Data registers hand the vector to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

### hw/rtl/fm_phase_discriminator.sv
// Path: input register, row of CORDIC cells, output register, in that order.
// Throughput: one item per cycle; the row of CORDIC cells advances as one pipeline
// and holds only while a finished result waits at the output under stall.
// Reset: asynchronous, active low; empties the pipeline, sets the previous phase
// to zero and the gain to 1.0 (4096 in Q4.12).
module fm_phase_discriminator #(
  parameter int CORDIC_STAGES = fmpd_pkg::CordicStagesDef,
  parameter int SAMPLE_BITS   = fmpd_pkg::SampleBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fmpd_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fmpd_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fmpd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [fmpd_pkg::ApbDataW-1:0]   pwdata,
  output logic [fmpd_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import fmpd_pkg::*;

  localparam int XW  = SAMPLE_BITS + 3;
  localparam int SHR = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int SHL = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;

  logic adv;
  logic cfg_wr;

  logic signed [GainW-1:0]  gain_q;
  logic [PhaseW-1:0]        last_phase_q;

  cell_ctl_t            ctl_c [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_c   [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_c   [CORDIC_STAGES+1];
  logic [PhaseW-1:0]    z_c   [CORDIC_STAGES+1];

  logic signed [39:0]   i_wide, q_wide;
  logic signed [XW-1:0] i_scl, q_scl;
  cell_ctl_t            pre_ctl_d;
  logic signed [XW-1:0] pre_x_d, pre_y_d;
  logic [PhaseW-1:0]    pre_z_d;

  logic [PhaseW-1:0]        phase;
  logic signed [PhaseW-1:0] diff;
  logic signed [31:0]       prod;
  logic signed [31:0]       prod_sh;

  logic      out_valid_q;
  out_item_t out_data_q;

  // The whole pipeline moves unless a result is held at the output.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign adv        = !in_stall_o;

  // Configuration port: single gain register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegDemodGain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_wr) begin
      gain_q <= signed'(pwdata[GainW-1:0]);
    end
  end

  always_comb begin
    if (paddr[2] == RegDemodGain) begin
      prdata = ApbDataW'(gain_q);
    end else begin
      prdata = '0;
    end
  end

  // Rescale samples to the datapath width and fold into the right half plane.
  always_comb begin
    i_wide = {{24{in_data_i.i_sample[15]}}, in_data_i.i_sample};
    q_wide = {{24{in_data_i.q_sample[15]}}, in_data_i.q_sample};
    i_scl  = XW'((i_wide >>> SHR) <<< SHL);
    q_scl  = XW'((q_wide >>> SHR) <<< SHL);
    pre_ctl_d.valid     = in_valid_i;
    pre_ctl_d.zero      = (i_scl == '0) && (q_scl == '0);
    pre_ctl_d.block_end = in_data_i.block_end;
    if (i_scl[XW-1]) begin
      pre_x_d = -i_scl;
      pre_y_d = -q_scl;
      pre_z_d = PhasePi;
    end else begin
      pre_x_d = i_scl;
      pre_y_d = q_scl;
      pre_z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c[0] <= '0;
    end else if (adv) begin
      ctl_c[0] <= pre_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_c[0] <= pre_x_d;
      y_c[0] <= pre_y_d;
      z_c[0] <= pre_z_d;
    end
  end

  // Row of CORDIC cells, one rotation each.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    fmpd_cell #(
      .XW    (XW),
      .STAGE (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl_c[k]),
      .x_i    (x_c[k]),
      .y_i    (y_c[k]),
      .z_i    (z_c[k]),
      .ctl_o  (ctl_c[k+1]),
      .x_o    (x_c[k+1]),
      .y_o    (y_c[k+1]),
      .z_o    (z_c[k+1])
    );
  end

  // Wrapped phase difference scaled by the gain; the x magnitude is unused.
  always_comb begin
    phase   = ctl_c[CORDIC_STAGES].zero ? '0 : z_c[CORDIC_STAGES];
    diff    = signed'(phase - last_phase_q);
    prod    = 32'(diff) * 32'(gain_q);
    prod_sh = prod >>> GainFracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      last_phase_q <= '0;
    end else if (adv) begin
      out_valid_q <= ctl_c[CORDIC_STAGES].valid;
      if (ctl_c[CORDIC_STAGES].valid) begin
        last_phase_q <= phase;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.demod_value   <= prod_sh[DemodW-1:0];
      out_data_q.block_end_out <= ctl_c[CORDIC_STAGES].block_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // An item leaving the last cell becomes the pending result.
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctl_c[CORDIC_STAGES].valid) |=> out_valid_o)
    else $error("item from last cell did not reach the output");

  // The previous phase only changes when an item reaches the output stage.
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && ctl_c[CORDIC_STAGES].valid) |=> $stable(last_phase_q))
    else $error("previous phase changed without an item");

  // A gain write lands in the register.
  a_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (gain_q == $past(signed'(pwdata[GainW-1:0]))))
    else $error("gain register write lost");

  // While stalled, the pipeline does not admit a new transfer.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(ctl_c[0]))
    else $error("first stage moved while stalled");
`endif

endmodule
